### hw/rtl/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg
// Types and constants shared by the soft-start ramp controller and datapath.
// ----------------------------------------------------------------------------
package ssr_pkg;

    // Duty is fixed point, full scale is 2^16 and needs 17 bits
    localparam int unsigned DUTY_W = 17;
    localparam logic [DUTY_W-1:0] FULL_DUTY = 17'h10000;

    // Configuration port
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATE_ON  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATE_OFF = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD   = 2'd2;

    localparam logic [CFG_W-1:0] RATE_ON_RST  = 16'd4295;
    localparam logic [CFG_W-1:0] RATE_OFF_RST = 16'd4295;
    localparam logic [CFG_W-1:0] PERIOD_RST   = 16'd1000;

    // Drive mode codes
    localparam logic [1:0] MODE_LOW  = 2'd0;
    localparam logic [1:0] MODE_HIGH = 2'd1;
    localparam logic [1:0] MODE_PWM  = 2'd2;

    // Input word kind
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MOVE,
        ST_CURVE,
        ST_SCALE,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic write_want;
        logic select;
        logic calc_step;
        logic move;
        logic curve_step;
        logic scale;
        logic emit;
    } ssr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic dt_zero;
        logic active;
        logic out_busy;
        logic curve_last;
    } ssr_status_t;

endpackage

### hw/rtl/sequential_soft_start_ramp_unit.sv
// ----------------------------------------------------------------------------
// sequential_soft_start_ramp_unit
// Soft-starts up to eight power switches one at a time. A set word records
// whether a channel is wanted on; a tick word with nonzero elapsed time either
// picks the lowest channel whose duty is off target (no output) or ramps the
// active channel linearly toward 0 or full scale and returns one word with the
// new duty, the on-time curved to duty^CURVE_POWER times the PWM period, the
// drive mode, and tlast set when the ramp is finished. A set word, a tick with
// zero time and a selecting tick go through decode only; a ramping tick also
// runs the move, curve, scale and emit states, the shared curve multiplier
// running CURVE_POWER - 1 passes, and waits in emit while the output register
// stays full. A new word is taken while the previous result still waits at
// the output.
// ----------------------------------------------------------------------------
module sequential_soft_start_ramp_unit
    import ssr_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int CURVE_POWER  = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // channel[7:0], want_on[8], elapsed_us[24:9]
    input  logic                  s_axis_tuser,   // operation
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // active_channel[2:0], duty_level[19:3],
                                                  // on_time_us[35:20], drive_mode[37:36]
    output logic                  m_axis_tlast    // ramp_done
);

    ssr_cmd_t          cmd;
    ssr_status_t       status;
    logic [2:0]        out_channel;
    logic [DUTY_W-1:0] out_duty;
    logic [15:0]       out_on_time;
    logic [1:0]        out_mode;

    // controller
    ssr_ctrl #(
        .CURVE_POWER (CURVE_POWER)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    ssr_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CURVE_POWER  (CURVE_POWER)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_op       (s_axis_tuser),
        .in_channel  (s_axis_tdata[7:0]),
        .in_want     (s_axis_tdata[8]),
        .in_dt       (s_axis_tdata[24:9]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_channel (out_channel),
        .out_duty    (out_duty),
        .out_on_time (out_on_time),
        .out_mode    (out_mode),
        .out_done    (m_axis_tlast)
    );

    // output word packing
    assign m_axis_tdata = {2'b00, out_mode, out_on_time, out_duty, out_channel};

`ifndef ASSERT_OFF
    // one word at a time: after an accept the input side closes
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // steady low exactly when the curved on-time is zero
    a_mode_low: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[35:20] == 16'd0) == (m_axis_tdata[37:36] == MODE_LOW)))
        else $error("drive mode does not match on-time");

    // a finished ramp sits at 0 or full scale, never in PWM
    a_done_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[37:36] != MODE_PWM))
        else $error("finished ramp reported in PWM mode");

    // duty never exceeds full scale
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[19:3] <= FULL_DUTY))
        else $error("duty above full scale");
`endif

endmodule

### hw/rtl/ssr_ctrl.sv
// ----------------------------------------------------------------------------
// ssr_ctrl
// Sequencer for one input word: decode, ramp step, curve multiplies, emit.
// ----------------------------------------------------------------------------
module ssr_ctrl
    import ssr_pkg::*;
#(
    parameter int CURVE_POWER = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ssr_status_t status,
    output ssr_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_tick && !status.dt_zero && status.active)
                begin
                    state_next = ST_MOVE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOVE:
            begin
                state_next = (CURVE_POWER > 1) ? ST_CURVE : ST_SCALE;
            end
            ST_CURVE:
            begin
                if (status.curve_last)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DECODE:
            begin
                if (!status.is_tick)
                begin
                    cmd.write_want = 1'b1;
                end
                else if (!status.dt_zero)
                begin
                    cmd.select    = !status.active;
                    cmd.calc_step = status.active;
                end
            end
            ST_MOVE:
            begin
                cmd.move = 1'b1;
            end
            ST_CURVE:
            begin
                cmd.curve_step = 1'b1;
            end
            ST_SCALE:
            begin
                cmd.scale = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### hw/rtl/ssr_datapath.sv
// ----------------------------------------------------------------------------
// ssr_datapath
// Channel state, configuration registers, ramp arithmetic and output word.
// ----------------------------------------------------------------------------
module ssr_datapath
    import ssr_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int CURVE_POWER  = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssr_cmd_t              cmd,
    output ssr_status_t           status,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // input word
    input  logic                  in_op,
    input  logic [7:0]            in_channel,
    input  logic                  in_want,
    input  logic [15:0]           in_dt,
    // output word
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            out_channel,
    output logic [DUTY_W-1:0]     out_duty,
    output logic [15:0]           out_on_time,
    output logic [1:0]            out_mode,
    output logic                  out_done
);

    localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CW  = (CURVE_POWER > 2) ? $clog2(CURVE_POWER - 1) : 1;
    localparam int CURVE_W = DUTY_W + 16;  // holds up to 2^32

    // configuration registers
    logic [CFG_W-1:0] rate_on_reg;
    logic [CFG_W-1:0] rate_off_reg;
    logic [CFG_W-1:0] period_reg;

    // latched input word
    logic        op_reg;
    logic [7:0]  ch_reg;
    logic        want_reg;
    logic [15:0] dt_reg;

    // channel state
    logic [NUM_CHANNELS-1:0] wanted_reg;
    logic [DUTY_W-1:0]       duty_reg [NUM_CHANNELS];
    logic                    active_reg;
    logic [CHW-1:0]          ramp_ch_reg;

    // working registers of one ramp step
    logic [31:0]         step_reg;
    logic [DUTY_W-1:0]   duty_cur_reg;
    logic                want_cur_reg;
    logic                done_reg;
    logic [CURVE_W-1:0]  curve_reg;
    logic [CW-1:0]       curve_cnt_reg;
    logic [15:0]         on_time_reg;

    // output register
    logic                out_valid_reg;
    logic [2:0]          out_channel_reg;
    logic [DUTY_W-1:0]   out_duty_reg;
    logic [15:0]         out_on_time_reg;
    logic [1:0]          out_mode_reg;
    logic                out_done_reg;

    logic                sel_found;
    logic [CHW-1:0]      sel_idx;
    logic [DUTY_W-1:0]   duty_rd;
    logic [DUTY_W-1:0]   target_rd;
    logic [CFG_W-1:0]    rate_sel;
    logic [DUTY_W-1:0]   target_cur;
    logic [DUTY_W-1:0]   err;
    logic [DUTY_W-1:0]   duty_new;
    logic [CURVE_W+DUTY_W-1:0] curve_prod;
    logic [CURVE_W+CFG_W-1:0]  scale_prod;
    logic [1:0]          mode;
    logic                set_in_range;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_on_reg  <= RATE_ON_RST;
            rate_off_reg <= RATE_OFF_RST;
            period_reg   <= PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_RATE_ON:  rate_on_reg  <= cfg_wdata;
                CFG_RATE_OFF: rate_off_reg <= cfg_wdata;
                CFG_PERIOD:   period_reg   <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // input word latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            ch_reg   <= in_channel;
            want_reg <= in_want;
            dt_reg   <= in_dt;
        end
    end

    // lowest channel whose duty is off its target
    always_comb
    begin
        sel_found = 1'b0;
        sel_idx   = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (duty_reg[i] != (wanted_reg[i] ? FULL_DUTY : '0))
            begin
                sel_found = 1'b1;
                sel_idx   = CHW'(i);
            end
        end
    end

    // ramp step arithmetic
    assign set_in_range = ({1'b0, ch_reg} < 9'(NUM_CHANNELS));
    assign duty_rd      = duty_reg[ramp_ch_reg];
    assign target_rd    = wanted_reg[ramp_ch_reg] ? FULL_DUTY : '0;
    assign rate_sel     = (duty_rd <= target_rd) ? rate_on_reg : rate_off_reg;
    assign target_cur   = want_cur_reg ? FULL_DUTY : '0;

    always_comb
    begin
        if (duty_cur_reg > target_cur)
        begin
            err      = duty_cur_reg - target_cur;
            duty_new = ({15'd0, err} < step_reg) ? target_cur
                                                 : duty_cur_reg - step_reg[DUTY_W-1:0];
        end
        else
        begin
            err      = target_cur - duty_cur_reg;
            duty_new = ({15'd0, err} < step_reg) ? target_cur
                                                 : duty_cur_reg + step_reg[DUTY_W-1:0];
        end
    end

    assign curve_prod = curve_reg * duty_cur_reg;
    assign scale_prod = curve_reg * period_reg;

    // drive mode from the curved on-time
    always_comb
    begin
        if (on_time_reg == '0)
        begin
            mode = MODE_LOW;
        end
        else if (on_time_reg >= period_reg)
        begin
            mode = MODE_HIGH;
        end
        else
        begin
            mode = MODE_PWM;
        end
    end

    // channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_reg  <= '0;
            active_reg  <= 1'b0;
            ramp_ch_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                duty_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.write_want && set_in_range)
            begin
                wanted_reg[ch_reg[CHW-1:0]] <= want_reg;
            end
            if (cmd.select && sel_found)
            begin
                active_reg  <= 1'b1;
                ramp_ch_reg <= sel_idx;
            end
            if (cmd.move)
            begin
                duty_reg[ramp_ch_reg] <= duty_new;
            end
            if (cmd.emit && done_reg)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.calc_step)
        begin
            step_reg     <= rate_sel * dt_reg;
            duty_cur_reg <= duty_rd;
            want_cur_reg <= wanted_reg[ramp_ch_reg];
        end
        if (cmd.move)
        begin
            duty_cur_reg  <= duty_new;
            done_reg      <= (duty_new == target_cur);
            curve_reg     <= {duty_new, 16'd0};
            curve_cnt_reg <= '0;
        end
        if (cmd.curve_step)
        begin
            curve_reg     <= curve_prod[CURVE_W+15:16];
            curve_cnt_reg <= curve_cnt_reg + 1'b1;
        end
        if (cmd.scale)
        begin
            on_time_reg <= scale_prod[47:32];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_channel_reg <= 3'(ramp_ch_reg);
            out_duty_reg    <= duty_cur_reg;
            out_on_time_reg <= on_time_reg;
            out_mode_reg    <= mode;
            out_done_reg    <= done_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign out_duty    = out_duty_reg;
    assign out_on_time = out_on_time_reg;
    assign out_mode    = out_mode_reg;
    assign out_done    = out_done_reg;

    // status to the controller
    assign status.is_tick    = (op_reg == OP_TICK);
    assign status.dt_zero    = (dt_reg == '0);
    assign status.active     = active_reg;
    assign status.out_busy   = out_valid_reg && !out_ready;
    assign status.curve_last = (curve_cnt_reg == CW'(CURVE_POWER - 2));

endmodule

### tb/ssr_ramp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssr_ramp_checker
// Watches the configuration port and both streams of the soft-start ramp
// unit, keeps its own copy of the channel state and registers, works out the
// ramp word each accepted tick should give, and compares every output word
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ssr_ramp_checker
    import ssr_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int CURVE_POWER  = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // channel[7:0], want_on[8], elapsed_us[24:9]
    input  logic                  s_axis_tuser,   // operation
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [39:0]           m_axis_tdata,   // active_channel[2:0], duty_level[19:3],
                                                  // on_time_us[35:20], drive_mode[37:36]
    input  logic                  m_axis_tlast,   // ramp_done
    output int                    errors,
    output int                    pending,
    output int                    checked
);

    typedef struct packed {
        logic [2:0]        channel;
        logic [DUTY_W-1:0] duty;
        logic [15:0]       on_time;
        logic [1:0]        mode;
        logic              done;
    } ramp_word_t;

    // Predicted ramp words, oldest first
    ramp_word_t ramp_words_q[$];

    // Shadow of the block's state and registers
    logic              want_on  [NUM_CHANNELS];
    logic [DUTY_W-1:0] duty_now [NUM_CHANNELS];
    logic              ramping;
    logic [2:0]        ramp_ch;
    logic [CFG_W-1:0]  rate_on_q;
    logic [CFG_W-1:0]  rate_off_q;
    logic [CFG_W-1:0]  period_q;

    function automatic logic [DUTY_W-1:0] target_of(input int unsigned idx);
        return want_on[idx] ? FULL_DUTY : '0;
    endfunction

    // duty^CURVE_POWER in Q32, truncated at each pass, then scaled by the period
    function automatic logic [15:0] curved_on_time(input logic [DUTY_W-1:0] duty);
        logic [63:0] acc;
        acc = {47'd0, duty} << 16;
        for (int k = 1; k < CURVE_POWER; k++)
            acc = (acc * {47'd0, duty}) >> 16;
        acc = (acc * {48'd0, period_q}) >> 32;
        return acc[15:0];
    endfunction

    // Apply one accepted input word; a ramping tick queues its output word
    task automatic take_word(input logic op, input logic [7:0] ch, input logic want,
                             input logic [15:0] dt);
        logic [DUTY_W-1:0] duty;
        logic [DUTY_W-1:0] target;
        logic [32:0]       step;
        logic [32:0]       gap;
        logic [15:0]       on_time;
        ramp_word_t        word;
        bit                found;
        int unsigned       idx;
        if (op == OP_SET) begin
            if (ch < NUM_CHANNELS)
                want_on[ch] = want;
        end
        else if (dt != 16'd0) begin
            if (!ramping) begin
                // pick the lowest channel that is off target
                found = 1'b0;
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (!found && duty_now[i] != target_of(i)) begin
                        found   = 1'b1;
                        ramping = 1'b1;
                        ramp_ch = 3'(i);
                    end
                end
            end
            else begin
                idx    = ramp_ch % NUM_CHANNELS;
                duty   = duty_now[idx];
                target = target_of(idx);
                step   = {17'd0, (duty <= target) ? rate_on_q : rate_off_q} * {17'd0, dt};
                if (duty > target) begin
                    gap  = 33'(duty) - 33'(target);
                    duty = (gap < step) ? target : duty - step[DUTY_W-1:0];
                end
                else begin
                    gap  = 33'(target) - 33'(duty);
                    duty = (gap < step) ? target : duty + step[DUTY_W-1:0];
                end
                duty_now[idx] = duty;
                on_time       = curved_on_time(duty);
                word.channel  = 3'(idx);
                word.duty     = duty;
                word.on_time  = on_time;
                if (on_time == 16'd0)
                    word.mode = MODE_LOW;
                else if (on_time >= period_q)
                    word.mode = MODE_HIGH;
                else
                    word.mode = MODE_PWM;
                word.done = (duty == target);
                if (word.done)
                    ramping = 1'b0;
                ramp_words_q.push_back(word);
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Monitor: output words first, then register writes, then input words
    always @(posedge clk or negedge rst_n)
    begin
        ramp_word_t exp_w;
        if (!rst_n) begin
            ramp_words_q.delete();
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                want_on[i]  = 1'b0;
                duty_now[i] = '0;
            end
            ramping    = 1'b0;
            ramp_ch    = '0;
            rate_on_q  = RATE_ON_RST;
            rate_off_q = RATE_OFF_RST;
            period_q   = PERIOD_RST;
            errors     = 0;
            checked    = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (ramp_words_q.size() == 0) begin
                    $error("output word with no prediction outstanding: tdata %h tlast %b",
                           m_axis_tdata, m_axis_tlast);
                    errors++;
                end
                else begin
                    exp_w = ramp_words_q.pop_front();
                    check_field("active_channel", 32'(exp_w.channel), 32'(m_axis_tdata[2:0]));
                    check_field("duty_level", 32'(exp_w.duty), 32'(m_axis_tdata[19:3]));
                    check_field("on_time_us", 32'(exp_w.on_time), 32'(m_axis_tdata[35:20]));
                    check_field("drive_mode", 32'(exp_w.mode), 32'(m_axis_tdata[37:36]));
                    check_field("ramp_done", 32'(exp_w.done), 32'(m_axis_tlast));
                    checked++;
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_RATE_ON:  rate_on_q  = cfg_wdata;
                    CFG_RATE_OFF: rate_off_q = cfg_wdata;
                    CFG_PERIOD:   period_q   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                take_word(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8],
                          s_axis_tdata[24:9]);
        end
        pending = ramp_words_q.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the sequential soft-start ramp unit: a directed opening that
// walks one channel up and down and hits the ignored and no-output cases,
// then random set and tick words over several register settings and idle
// patterns. The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import ssr_pkg::*;

    localparam int NCH           = 4;
    localparam int CURVE_POW     = 2;
    localparam int NUM_PHASES    = 6;
    localparam int WORDS_PER_PH  = 225;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // channel[7:0], want_on[8], elapsed_us[24:9]
    logic                  s_axis_tuser;   // operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [39:0]           m_axis_tdata;   // active_channel[2:0], duty_level[19:3],
                                           // on_time_us[35:20], drive_mode[37:36]
    logic                  m_axis_tlast;   // ramp_done

    int  errors;
    int  pending;
    int  checked;
    int  cycle_count;
    int  words_sent;
    int  ticks_sent;
    int  settings_used;
    int  idle_pct;
    bit  send_idle;
    bit  recv_stall;

    sequential_soft_start_ramp_unit #(
        .NUM_CHANNELS (NCH),
        .CURVE_POWER  (CURVE_POW)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    ssr_ramp_checker #(
        .NUM_CHANNELS (NCH),
        .CURVE_POWER  (CURVE_POW)
    ) u_ramp_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: ready held low with a chance of idle_pct percent while stalling
    always @(posedge clk)
    begin
        m_axis_tready <= recv_stall ? ($urandom_range(99) >= idle_pct) : 1'b1;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Present one word and hold it until accepted; optional idle gap first
    task automatic send_word(input logic op, input logic [7:0] ch, input logic want,
                             input logic [15:0] dt);
        if (send_idle) begin
            while ($urandom_range(99) < idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, dt, want, ch};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
        if (op == OP_TICK)
            ticks_sent++;
    endtask

    // Hold off the sender until every predicted word is out and the block is quiet
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] ron, input logic [CFG_W-1:0] roff,
                                 input logic [CFG_W-1:0] per);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_RATE_ON;
        cfg_wdata <= ron;
        @(posedge clk);
        cfg_addr  <= CFG_RATE_OFF;
        cfg_wdata <= roff;
        @(posedge clk);
        cfg_addr  <= CFG_PERIOD;
        cfg_wdata <= per;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Mostly short steps so ramps take several ticks; some zero and full range
    function automatic logic [15:0] pick_elapsed();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return 16'd0;
        else if (r < 65)
            return 16'($urandom_range(20, 1));
        else if (r < 90)
            return 16'($urandom_range(1000, 21));
        else
            return 16'($urandom_range(65535));
    endfunction

    task automatic send_random();
        logic       op;
        logic [7:0] ch;
        op = ($urandom_range(99) < 62) ? OP_TICK : OP_SET;
        ch = ($urandom_range(99) < 88) ? 8'($urandom_range(NCH - 1)) : 8'($urandom_range(255));
        send_word(op, ch, 1'($urandom_range(1)), pick_elapsed());
    endtask

    initial
    begin
        logic [CFG_W-1:0] ron_set  [NUM_PHASES];
        logic [CFG_W-1:0] roff_set [NUM_PHASES];
        logic [CFG_W-1:0] per_set  [NUM_PHASES];

        // extremes, slow and uneven rates, zero rates, zero period, random
        ron_set  = '{16'd65535, 16'd300,  16'd0,   16'd2000, 16'd40,   16'd0};
        roff_set = '{16'd65535, 16'd7000, 16'd5000, 16'd0,   16'd90,   16'd0};
        per_set  = '{16'd65535, 16'd1,    16'd500,  16'd0,   16'd1000, 16'd0};
        ron_set[5]  = 16'($urandom_range(65535));
        roff_set[5] = 16'($urandom_range(65535));
        per_set[5]  = 16'($urandom_range(65535, 1));

        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_SET;
        m_axis_tready = 1'b0;
        send_idle     = 1'b0;
        recv_stall    = 1'b0;
        idle_pct      = 72;
        cycle_count   = 0;
        words_sent    = 0;
        ticks_sent    = 0;
        settings_used = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset register values
        send_word(OP_TICK, 8'd0,   1'b0, 16'd0);      // zero elapsed time
        send_word(OP_TICK, 8'd0,   1'b0, 16'd5);      // nothing off target
        send_word(OP_SET,  8'hFF,  1'b1, 16'hFFFF);   // channel out of range
        send_word(OP_SET,  8'd4,   1'b1, 16'd0);      // first channel past the end
        send_word(OP_TICK, 8'hFF,  1'b1, 16'd9);
        send_word(OP_SET,  8'd0,   1'b1, 16'd0);
        send_word(OP_SET,  8'd3,   1'b1, 16'd0);
        send_word(OP_TICK, 8'd0,   1'b0, 16'd1);      // selects channel 0, no word
        send_word(OP_TICK, 8'd0,   1'b0, 16'd0);
        send_word(OP_TICK, 8'd0,   1'b0, 16'd3);      // partial ramp up
        send_word(OP_TICK, 8'd0,   1'b0, 16'hFFFF);   // reaches full scale
        send_word(OP_TICK, 8'd0,   1'b0, 16'd10);     // selects channel 3
        send_word(OP_TICK, 8'd0,   1'b0, 16'd2);
        send_word(OP_SET,  8'd3,   1'b0, 16'd0);      // target flips mid-ramp
        send_word(OP_TICK, 8'd0,   1'b0, 16'd1);
        send_word(OP_TICK, 8'd0,   1'b0, 16'hFFFF);   // back to zero
        send_word(OP_SET,  8'd0,   1'b0, 16'd0);
        send_word(OP_TICK, 8'd0,   1'b0, 16'd1);
        send_word(OP_TICK, 8'd0,   1'b0, 16'd8);      // partial ramp down
        send_word(OP_TICK, 8'd0,   1'b0, 16'hFFFF);
        send_word(OP_SET,  8'd1,   1'b1, 16'd0);
        send_word(OP_SET,  8'd2,   1'b1, 16'd0);
        send_word(OP_TICK, 8'd0,   1'b0, 16'd4);
        send_word(OP_TICK, 8'd0,   1'b0, 16'd4);

        // Random part: new register setting and idle pattern per phase
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            load_settings(ron_set[ph], roff_set[ph], per_set[ph]);
            send_idle  = (ph == 1) || (ph == 3) || (ph == 5);
            recv_stall = (ph == 2) || (ph == 3) || (ph == 5);
            // idle on both sides at once uses the lighter ratio
            idle_pct   = (send_idle && recv_stall) ? 36 : 72;
            for (int n = 0; n < WORDS_PER_PH; n++) begin
                send_random();
                if (ph == 2 && n == WORDS_PER_PH / 2)
                    drain_results();
            end
        end

        drain_results();
        repeat (32) @(posedge clk);

        $display("Run covered %0d input words (%0d ticks) over %0d register settings;",
                 words_sent, ticks_sent, settings_used + 1);
        $display("%0d ramp words were checked against prediction, %0d mismatches.",
                 checked, errors);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
